### sv/oaht_pkg.sv
// Shared types and constants for the open-address hash table unit.
// No dependencies; the design files refer to it by scoped names and the testbench imports it.
`timescale 1ns / 1ps

package oaht_pkg;

  // Field widths fixed by the item format.
  localparam int ACT_W  = 2;
  localparam int KEY_W  = 16;
  localparam int VAL_W  = 16;
  localparam int CNT_W  = 8;
  localparam int MOD_W  = 7;
  localparam int STAT_W = 2;

  // Default storage depth and the largest modulus the register can hold.
  localparam int DEFAULT_TABLE_DEPTH = 128;
  localparam int MOD_LIMIT           = 127;
  localparam logic [MOD_W-1:0] MOD_RESET = 7'd127;

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
  localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd2;
  localparam logic [ACT_W-1:0] ACT_NONE   = 2'd3;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  // One table slot; a probe count of zero marks the slot empty.
  typedef struct packed {
    logic [CNT_W-1:0] probes;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  // Result of the serial modulo unit.
  typedef struct packed {
    logic             done;
    logic [MOD_W-1:0] rem;
  } div_rsp_t;

endpackage

### sv/oaht_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing; used for the slot store of the hash table unit.
`timescale 1ns / 1ps

module oaht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/oaht_mod_unit.sv
// Serial restoring modulo unit: key mod divisor, one dividend bit per cycle.
// Depends on oaht_pkg for widths and the response struct.
`timescale 1ns / 1ps

module oaht_mod_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [oaht_pkg::KEY_W-1:0] dividend,
  input  logic [oaht_pkg::MOD_W-1:0] divisor,
  output oaht_pkg::div_rsp_t        rsp
);

  localparam int STEP_W = $clog2(oaht_pkg::KEY_W);

  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [STEP_W-1:0]          step_r, step_nxt;
  logic [oaht_pkg::MOD_W-1:0] rem_r, rem_nxt;
  logic [oaht_pkg::KEY_W-1:0] quo_r, quo_nxt;
  logic [oaht_pkg::MOD_W-1:0] div_r, div_nxt;
  logic [oaht_pkg::MOD_W:0]   trial;

  // Shift the next dividend bit into the partial remainder.
  assign trial = {rem_r, quo_r[oaht_pkg::KEY_W-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      div_nxt  = divisor;
    end else if (busy_r) begin
      // Subtract the divisor when the trial remainder reaches it.
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = oaht_pkg::MOD_W'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = trial[oaht_pkg::MOD_W-1:0];
      end
      quo_nxt  = {quo_r[oaht_pkg::KEY_W-2:0], 1'b0};
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(oaht_pkg::KEY_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state is reset; the datapath needs none.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

### sv/open_address_hash_table_unit.sv
// Open-address hash table with triangular probing over a two-port (write, read) RAM.
// Insert/lookup: accept, key mod M in the serial modulo unit, then per probe a RAM
// read (S_READ) and a slot check (S_EVAL), then a load into the output register.
// Clear: one RAM entry per cycle over min(TABLE_DEPTH, 128) entries, then result.
// After reset the same clearing pass runs, without a result, before the
// first input transfer is taken; configuration writes are taken at any time.
`timescale 1ns / 1ps

module open_address_hash_table_unit #(
  parameter int TABLE_DEPTH = oaht_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [oaht_pkg::MOD_W-1:0]  cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [oaht_pkg::ACT_W-1:0]  in_action,
  input  logic [oaht_pkg::KEY_W-1:0]  in_key,
  input  logic [oaht_pkg::VAL_W-1:0]  in_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [oaht_pkg::STAT_W-1:0] out_status,
  output logic [oaht_pkg::VAL_W-1:0]  out_found_value,
  output logic [oaht_pkg::CNT_W-1:0]  out_probe_count
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int MAX_M = (TABLE_DEPTH - 1 > oaht_pkg::MOD_LIMIT) ?
                         oaht_pkg::MOD_LIMIT : TABLE_DEPTH - 1;
  localparam int CLEAR_SPAN = (TABLE_DEPTH > oaht_pkg::MOD_LIMIT + 1) ?
                              oaht_pkg::MOD_LIMIT + 1 : TABLE_DEPTH;
  localparam int CW = $clog2(CLEAR_SPAN);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_HASH  = 6'b000100,
    S_READ  = 6'b001000,
    S_EVAL  = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [oaht_pkg::MOD_W-1:0]    modulus_r;
  logic [oaht_pkg::MOD_W-1:0]    eff_m;
  logic [oaht_pkg::MOD_W-1:0]    m_r, m_nxt;
  logic [oaht_pkg::ACT_W-1:0]    act_r, act_nxt;
  logic [oaht_pkg::KEY_W-1:0]    key_r, key_nxt;
  logic [oaht_pkg::VAL_W-1:0]    val_r, val_nxt;
  logic [oaht_pkg::MOD_W-1:0]    adr_r, adr_nxt;
  logic [oaht_pkg::CNT_W-1:0]    n_r, n_nxt;
  logic [CW-1:0]                 clr_cnt_r, clr_cnt_nxt;
  logic                          clr_emit_r, clr_emit_nxt;
  logic [oaht_pkg::STAT_W-1:0]   res_st_r, res_st_nxt;
  logic [oaht_pkg::VAL_W-1:0]    res_val_r, res_val_nxt;
  logic [oaht_pkg::CNT_W-1:0]    res_cnt_r, res_cnt_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [oaht_pkg::STAT_W-1:0]   out_st_r;
  logic [oaht_pkg::VAL_W-1:0]    out_val_r;
  logic [oaht_pkg::CNT_W-1:0]    out_cnt_r;
  logic                          out_load;
  logic                          in_xfer;
  logic                          div_start;
  oaht_pkg::div_rsp_t            div_rsp;
  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  oaht_pkg::slot_t               ram_wdata;
  logic                          ram_re;
  oaht_pkg::slot_t               ram_rdata;
  logic [oaht_pkg::CNT_W-1:0]    adr_sum;

  // Effective modulus: zero acts as one, capped below the table depth.
  always_comb begin
    eff_m = modulus_r;
    if (modulus_r == '0) begin
      eff_m = oaht_pkg::MOD_W'(1);
    end
    if (modulus_r > oaht_pkg::MOD_W'(MAX_M)) begin
      eff_m = oaht_pkg::MOD_W'(MAX_M);
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= oaht_pkg::MOD_RESET;
    end else if (cfg_wr_en) begin
      modulus_r <= cfg_wr_data;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign div_start = in_xfer &&
                     (in_action == oaht_pkg::ACT_INSERT || in_action == oaht_pkg::ACT_LOOKUP);

  oaht_mod_unit u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_key),
    .divisor  (eff_m),
    .rsp      (div_rsp)
  );

  oaht_ram #(
    .WIDTH (oaht_pkg::SLOT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (AW'(adr_r)),
    .rdata (ram_rdata)
  );

  // Next probe address: adr + n stays below twice the modulus.
  assign adr_sum = {1'b0, adr_r} + n_r;

  // The output register is free when empty or being taken this cycle.
  assign out_load = (state_r == S_EMIT) && (!out_valid_r || !out_stall);

  // Probe sequencer.
  always_comb begin
    state_nxt    = state_r;
    m_nxt        = m_r;
    act_nxt      = act_r;
    key_nxt      = key_r;
    val_nxt      = val_r;
    adr_nxt      = adr_r;
    n_nxt        = n_r;
    clr_cnt_nxt  = clr_cnt_r;
    clr_emit_nxt = clr_emit_r;
    res_st_nxt   = res_st_r;
    res_val_nxt  = res_val_r;
    res_cnt_nxt  = res_cnt_r;
    ram_we       = 1'b0;
    ram_waddr    = AW'(adr_r);
    ram_wdata    = '0;
    ram_re       = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = AW'(clr_cnt_r);
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == CW'(CLEAR_SPAN - 1)) begin
          res_st_nxt  = oaht_pkg::ST_OK;
          res_val_nxt = '0;
          res_cnt_nxt = '0;
          state_nxt   = clr_emit_r ? S_EMIT : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          act_nxt = in_action;
          key_nxt = in_key;
          val_nxt = in_value;
          m_nxt   = eff_m;
          unique case (in_action)
            oaht_pkg::ACT_CLEAR: begin
              clr_cnt_nxt  = '0;
              clr_emit_nxt = 1'b1;
              state_nxt    = S_CLEAR;
            end
            oaht_pkg::ACT_INSERT, oaht_pkg::ACT_LOOKUP: begin
              state_nxt = S_HASH;
            end
            default: begin
              res_st_nxt  = oaht_pkg::ST_MISS;
              res_val_nxt = '0;
              res_cnt_nxt = '0;
              state_nxt   = S_EMIT;
            end
          endcase
        end
      end
      S_HASH: begin
        if (div_rsp.done) begin
          adr_nxt   = div_rsp.rem;
          n_nxt     = oaht_pkg::CNT_W'(1);
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        ram_re    = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        priority if (ram_rdata.probes == '0) begin
          // Empty slot ends both insert and lookup.
          if (act_r == oaht_pkg::ACT_INSERT) begin
            ram_we           = 1'b1;
            ram_wdata.probes = n_r;
            ram_wdata.key    = key_r;
            ram_wdata.value  = val_r;
            res_st_nxt       = oaht_pkg::ST_OK;
          end else begin
            res_st_nxt       = oaht_pkg::ST_MISS;
          end
          res_val_nxt = '0;
          res_cnt_nxt = n_r;
          state_nxt   = S_EMIT;
        end else if (act_r == oaht_pkg::ACT_LOOKUP && ram_rdata.key == key_r) begin
          res_st_nxt  = oaht_pkg::ST_OK;
          res_val_nxt = ram_rdata.value;
          res_cnt_nxt = n_r;
          state_nxt   = S_EMIT;
        end else if (n_r == {1'b0, m_r}) begin
          res_st_nxt  = oaht_pkg::ST_FULL;
          res_val_nxt = '0;
          res_cnt_nxt = {1'b0, m_r};
          state_nxt   = S_EMIT;
        end else begin
          if (adr_sum >= {1'b0, m_r}) begin
            adr_nxt = oaht_pkg::MOD_W'(adr_sum - {1'b0, m_r});
          end else begin
            adr_nxt = adr_sum[oaht_pkg::MOD_W-1:0];
          end
          n_nxt     = n_r + 1'b1;
          state_nxt = S_READ;
        end
      end
      S_EMIT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register valid: set on load, cleared when the transfer completes.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state is reset; payload registers are not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      clr_emit_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_emit_r  <= clr_emit_nxt;
      out_valid_r <= out_valid_nxt;
    end
    m_r       <= m_nxt;
    act_r     <= act_nxt;
    key_r     <= key_nxt;
    val_r     <= val_nxt;
    adr_r     <= adr_nxt;
    n_r       <= n_nxt;
    res_st_r  <= res_st_nxt;
    res_val_r <= res_val_nxt;
    res_cnt_r <= res_cnt_nxt;
    if (out_load) begin
      out_st_r  <= res_st_r;
      out_val_r <= res_val_r;
      out_cnt_r <= res_cnt_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_st_r;
  assign out_found_value = out_val_r;
  assign out_probe_count = out_cnt_r;

endmodule

### sim/tb_open_address_hash_table_unit.sv
// Self-checking testbench for open_address_hash_table_unit.
// Depends on oaht_pkg (sv/oaht_pkg.sv) and the unit itself; it keeps a shadow copy of
// the slot table, predicts every result, and runs directed cases followed by random phases.
`timescale 1ns / 1ps

module tb_open_address_hash_table_unit;
  import oaht_pkg::*;

  localparam int TBL_DEPTH = DEFAULT_TABLE_DEPTH;

  // One result transfer as the unit reports it.
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  found;
    logic [CNT_W-1:0]  probes;
  } table_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [MOD_W-1:0]  cfg_wr_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [ACT_W-1:0]  in_action = ACT_CLEAR;
  logic [KEY_W-1:0]  in_key = '0;
  logic [VAL_W-1:0]  in_value = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [STAT_W-1:0] out_status;
  logic [VAL_W-1:0]  out_found_value;
  logic [CNT_W-1:0]  out_probe_count;

  // Shadow of the slot table and the modulus register.
  logic [KEY_W-1:0] shadow_key    [TBL_DEPTH];
  logic [VAL_W-1:0] shadow_value  [TBL_DEPTH];
  logic [CNT_W-1:0] shadow_probes [TBL_DEPTH];
  logic [MOD_W-1:0] modulus_shadow = MOD_RESET;

  table_result_t    pending_results[$];
  logic [KEY_W-1:0] live_keys[$];
  int               fail_count = 0;
  int               send_idle_pct = 0;
  int               recv_stall_pct = 0;

  open_address_hash_table_unit #(
    .TABLE_DEPTH(TBL_DEPTH)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_key         (in_key),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_found_value(out_found_value),
    .out_probe_count(out_probe_count)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Hard stop in case the unit hangs.
  initial begin
    #50_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic void wipe_table();
    int i;
    for (i = 0; i < TBL_DEPTH; i++) begin
      shadow_key[i]    = '0;
      shadow_value[i]  = '0;
      shadow_probes[i] = '0;
    end
  endfunction

  // Applies one operation to the shadow table and returns the result it must produce.
  function automatic table_result_t apply_table_op(input logic [ACT_W-1:0] act,
                                                   input logic [KEY_W-1:0] key,
                                                   input logic [VAL_W-1:0] val);
    int unsigned   m;
    int unsigned   slot;
    int unsigned   n;
    table_result_t res;
    res = '{status: ST_OK, found: '0, probes: '0};
    m = 32'(modulus_shadow);
    if (m == 0) m = 1;
    if (m > TBL_DEPTH - 1) m = TBL_DEPTH - 1;
    if (act == ACT_CLEAR) begin
      wipe_table();
      return res;
    end
    if (act == ACT_NONE) begin
      res.status = ST_MISS;
      return res;
    end
    slot = key % m;
    for (n = 1; n <= m; n++) begin
      if (act == ACT_INSERT) begin
        if (shadow_probes[slot] == 0) begin
          shadow_key[slot]    = key;
          shadow_value[slot]  = val;
          shadow_probes[slot] = n[CNT_W-1:0];
          res.probes = n[CNT_W-1:0];
          return res;
        end
      end else begin
        // An empty slot ends the search before any key compare.
        if (shadow_probes[slot] == 0) begin
          res.status = ST_MISS;
          res.probes = n[CNT_W-1:0];
          return res;
        end
        if (shadow_key[slot] == key) begin
          res.found  = shadow_value[slot];
          res.probes = n[CNT_W-1:0];
          return res;
        end
      end
      slot = (slot + n) % m;
    end
    // Every reachable slot was examined without success.
    res.status = ST_FULL;
    res.probes = m[CNT_W-1:0];
    return res;
  endfunction

  initial wipe_table();

  function automatic void report_mismatch(input string field, input int want, input int got);
    fail_count++;
    $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endfunction

  // Result side: compare each transfer with the oldest prediction, then pick the next stall.
  always @(posedge clk) begin : result_check
    table_result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, status", -1, int'(out_status));
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", int'(want.status), int'(out_status));
        if (out_found_value !== want.found)
          report_mismatch("found_value", int'(want.found), int'(out_found_value));
        if (out_probe_count !== want.probes)
          report_mismatch("probe_count", int'(want.probes), int'(out_probe_count));
      end
    end
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // Presents one item, holds it until the transfer, and records its prediction.
  task automatic send_op(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] key,
                         input logic [VAL_W-1:0] val);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_action <= act;
    in_key    <= key;
    in_value  <= val;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    pending_results.insert(pending_results.size(), apply_table_op(act, key, val));
  endtask

  // Stops sending and waits until every predicted result has arrived.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_modulus(input logic [MOD_W-1:0] modulus);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= modulus;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    modulus_shadow = modulus;
  endtask

  // Lookups on the freshly reset table, including key zero against empty slots.
  task automatic test_empty_table();
    send_op(ACT_LOOKUP, 16'h0000, 16'h0000);
    send_op(ACT_LOOKUP, 16'hFFFF, 16'hFFFF);
  endtask

  // Extreme keys and values, plus a collision on the home slot of key zero.
  task automatic test_insert_extremes();
    send_op(ACT_INSERT, 16'h0000, 16'hFFFF);
    send_op(ACT_INSERT, 16'hFFFF, 16'h0000);
    send_op(ACT_INSERT, 16'd127, 16'h1234);
    send_op(ACT_LOOKUP, 16'h0000, 16'h0000);
    send_op(ACT_LOOKUP, 16'hFFFF, 16'h0000);
    send_op(ACT_LOOKUP, 16'd127, 16'h0000);
  endtask

  // A second insert of the same key lands further along; lookup still finds the first.
  task automatic test_duplicate_key();
    send_op(ACT_INSERT, 16'h0000, 16'h5555);
    send_op(ACT_LOOKUP, 16'h0000, 16'hAAAA);
  endtask

  task automatic test_unused_action();
    send_op(ACT_NONE, 16'h0000, 16'hFFFF);
  endtask

  task automatic test_clear();
    send_op(ACT_CLEAR, 16'hFFFF, 16'hFFFF);
    send_op(ACT_LOOKUP, 16'h0000, 16'h0000);
  endtask

  // With a modulus of one the single slot fills at once.
  task automatic test_table_full();
    drain_results();
    write_modulus(7'd1);
    send_op(ACT_INSERT, 16'd5, 16'd1);
    send_op(ACT_INSERT, 16'd9, 16'd2);
    send_op(ACT_LOOKUP, 16'd9, 16'd0);
    send_op(ACT_LOOKUP, 16'd5, 16'd0);
  endtask

  // A modulus of zero behaves as one.
  task automatic test_zero_modulus();
    drain_results();
    write_modulus(7'd0);
    send_op(ACT_INSERT, 16'd3, 16'hBEEF);
    send_op(ACT_CLEAR, 16'd0, 16'd0);
    send_op(ACT_INSERT, 16'd3, 16'hBEEF);
    send_op(ACT_LOOKUP, 16'd3, 16'd0);
  endtask

  // Mostly inserts and lookups, lookups mostly of keys already stored, with occasional clears and noise.
  task automatic test_random_phase(input logic [MOD_W-1:0] modulus, input int n_items,
                                   input int idle_pct, input int stall_pct);
    int               i;
    int unsigned      pick;
    int unsigned      clear_pct;
    logic [ACT_W-1:0] act;
    logic [KEY_W-1:0] key;
    drain_results();
    write_modulus(modulus);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    clear_pct = (modulus > 32) ? 1 : 3;
    for (i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      key  = KEY_W'($urandom_range(16'hFFFF));
      if (pick < clear_pct) begin
        act = ACT_CLEAR;
      end else if (pick < clear_pct + 2) begin
        act = ACT_NONE;
      end else if (pick < 50) begin
        act = ACT_INSERT;
        if (live_keys.size() != 0 && $urandom_range(99) < 15)
          key = live_keys[$urandom_range(live_keys.size() - 1)];
      end else begin
        act = ACT_LOOKUP;
        if (live_keys.size() != 0 && $urandom_range(99) < 70)
          key = live_keys[$urandom_range(live_keys.size() - 1)];
      end
      send_op(act, key, VAL_W'($urandom_range(16'hFFFF)));
      if (act == ACT_CLEAR) begin
        live_keys.delete();
      end else if (act == ACT_INSERT) begin
        live_keys.insert(live_keys.size(), key);
        if (live_keys.size() > 128) void'(live_keys.pop_front());
      end
      // Now and then hold off until the unit has delivered everything.
      if ($urandom_range(199) == 0) drain_results();
    end
  endtask

  // Test sequence.
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_table();
    test_insert_extremes();
    test_duplicate_key();
    test_unused_action();
    test_clear();
    test_table_full();
    test_zero_modulus();
    test_random_phase(7'd127, 150, 0, 0);
    test_random_phase(7'd5, 100, 78, 0);
    test_random_phase(7'd0, 40, 0, 78);
    test_random_phase(7'd1, 40, 18, 18);
    test_random_phase(7'd16, 120, 0, 0);
    test_random_phase(7'd31, 120, 78, 0);
    test_random_phase(7'd64, 150, 0, 78);
    test_random_phase(7'd100, 120, 18, 18);
    test_random_phase(7'd2, 60, 0, 0);
    test_random_phase(7'd7, 100, 18, 18);
    test_random_phase(7'd127, 150, 0, 0);
    drain_results();
    repeat (300) @(posedge clk);
    if (pending_results.size() != 0) begin
      fail_count++;
      $display("%0t ns: %0d results never arrived", $time, pending_results.size());
    end
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### sim.f
sv/oaht_pkg.sv
sv/oaht_ram.sv
sv/oaht_mod_unit.sv
sv/open_address_hash_table_unit.sv
sim/tb_open_address_hash_table_unit.sv
